// ----- hw/rtl/bsscb_pkg.sv -----
// ----------------------------------------------------------------------------
// bsscb_pkg
// Shared constants, command codes and lane status type for the bit-sliced
// saturating counter bank.
// ----------------------------------------------------------------------------
package bsscb_pkg;

  localparam int TAG_BITS = 32;   // counters in the bank, 1 to 64
  localparam int PLANES   = 8;    // bits per counter, 1 to 16

  localparam int MASK_W   = 32;   // width of bit_mask and nonzero_mask
  localparam int CMD_W    = 2;
  localparam int PLANE_W  = 3;    // width of weight_plane

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_DEC   = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  // Status of one counter after the update.
  typedef struct packed {
    logic nonzero;
    logic multi;
  } lane_flags_t;

endpackage

// ----- hw/rtl/bsscb_if.sv -----
// ----------------------------------------------------------------------------
// bsscb_cmd_if / bsscb_res_if
// Valid/ready channels for commands into and results out of the bank.
// ----------------------------------------------------------------------------
interface bsscb_cmd_if;
  logic                            valid;
  logic                            ready;
  logic [bsscb_pkg::CMD_W-1:0]     command;
  logic [bsscb_pkg::MASK_W-1:0]    bit_mask;
  logic [bsscb_pkg::PLANE_W-1:0]   weight_plane;

  modport source (output valid, command, bit_mask, weight_plane, input ready);
  modport sink   (input valid, command, bit_mask, weight_plane, output ready);
endinterface

interface bsscb_res_if;
  logic                            valid;
  logic                            ready;
  logic [bsscb_pkg::MASK_W-1:0]    nonzero_mask;
  logic                            mask_hit;
  logic                            mask_multi_hit;
  logic                            any_multi;

  modport source (output valid, nonzero_mask, mask_hit, mask_multi_hit, any_multi,
                  input ready);
  modport sink   (input valid, nonzero_mask, mask_hit, mask_multi_hit, any_multi,
                  output ready);
endinterface

// ----- hw/rtl/bsscb_lane.sv -----
// ----------------------------------------------------------------------------
// bsscb_lane
// One saturating counter of the bank: holds its plane bits and applies
// clear, weighted add and decrement.
// ----------------------------------------------------------------------------
module bsscb_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  bsscb_pkg::cmd_t               cmd,
  input  logic                          sel,
  input  logic [bsscb_pkg::PLANE_W-1:0] plane,
  output bsscb_pkg::lane_flags_t        flags
);

  logic [bsscb_pkg::PLANES-1:0] count;
  logic [bsscb_pkg::PLANES-1:0] count_next;
  logic [bsscb_pkg::PLANES:0]   inc;
  logic [bsscb_pkg::PLANES:0]   sum;
  logic                         over;

  always_comb begin
    over = (int'(plane) >= bsscb_pkg::PLANES);
    inc  = '0;
    if (!over) begin
      inc = (bsscb_pkg::PLANES + 1)'(1) << plane;
    end
    sum = {1'b0, count} + inc;

    count_next = count;
    if (en) begin
      case (cmd)
        bsscb_pkg::CMD_CLEAR: count_next = '0;
        bsscb_pkg::CMD_ADD: begin
          if (sel) begin
            // saturate on carry out of the top plane
            if (over || sum[bsscb_pkg::PLANES]) begin
              count_next = '1;
            end else begin
              count_next = sum[bsscb_pkg::PLANES-1:0];
            end
          end
        end
        bsscb_pkg::CMD_DEC: begin
          if (sel && (count != '0)) begin
            count_next = count - bsscb_pkg::PLANES'(1);
          end
        end
        bsscb_pkg::CMD_QUERY: count_next = count;
        default:              count_next = count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign flags.nonzero = (count_next != '0);
  assign flags.multi   = ({1'b0, count_next} >= (bsscb_pkg::PLANES + 1)'(2));

endmodule

// ----- hw/rtl/bsscb_merge.sv -----
// ----------------------------------------------------------------------------
// bsscb_merge
// Combines the lane flags into one result and holds it in the output
// register until the transfer.
// ----------------------------------------------------------------------------
module bsscb_merge (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           take,
  input  bsscb_pkg::lane_flags_t         flags [bsscb_pkg::TAG_BITS],
  input  logic [bsscb_pkg::TAG_BITS-1:0] sel,
  bsscb_res_if.source                    res_ch
);

  logic [bsscb_pkg::TAG_BITS-1:0] nz_vec;
  logic [bsscb_pkg::TAG_BITS-1:0] multi_vec;
  logic [bsscb_pkg::MASK_W-1:0]   nz_mask;
  logic                           hit;
  logic                           multi_hit;
  logic                           any_m;

  logic                           valid;
  logic [bsscb_pkg::MASK_W-1:0]   nonzero_mask;
  logic                           mask_hit;
  logic                           mask_multi_hit;
  logic                           any_multi;

  for (genvar i = 0; i < bsscb_pkg::TAG_BITS; i++) begin : g_vec
    assign nz_vec[i]    = flags[i].nonzero;
    assign multi_vec[i] = flags[i].multi;
  end

  for (genvar i = 0; i < bsscb_pkg::MASK_W; i++) begin : g_mask
    if (i < bsscb_pkg::TAG_BITS) begin : g_in
      assign nz_mask[i] = nz_vec[i];
    end else begin : g_out
      assign nz_mask[i] = 1'b0;
    end
  end

  assign hit       = |(nz_vec & sel);
  assign multi_hit = |(multi_vec & sel);
  assign any_m     = |multi_vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (res_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      nonzero_mask   <= nz_mask;
      mask_hit       <= hit;
      mask_multi_hit <= multi_hit;
      any_multi      <= any_m;
    end
  end

  assign res_ch.valid          = valid;
  assign res_ch.nonzero_mask   = nonzero_mask;
  assign res_ch.mask_hit       = mask_hit;
  assign res_ch.mask_multi_hit = mask_multi_hit;
  assign res_ch.any_multi      = any_multi;

endmodule

// ----- hw/rtl/bit_sliced_saturating_counter_bank_core.sv -----
// ----------------------------------------------------------------------------
// bit_sliced_saturating_counter_bank_core
// Bank of saturating counters, one lane per tag bit, with a merge stage
// that reports nonzero and multi-count status after each command.
// ----------------------------------------------------------------------------
// The result is valid in the cycle after the command transfer.
// Throughput: one command per cycle; every lane updates its counter in the
//   accept cycle and the merged status goes straight to the output register.
// A command is taken while the previous result waits only if the sink is ready.
// Reset: all counters zero, output register empty.
module bit_sliced_saturating_counter_bank_core (
  input  logic        clk,
  input  logic        rst,
  bsscb_cmd_if.sink   cmd_ch,
  bsscb_res_if.source res_ch
);

  logic                           take;
  logic [bsscb_pkg::TAG_BITS-1:0] sel;
  bsscb_pkg::lane_flags_t         flags [bsscb_pkg::TAG_BITS];
  bsscb_pkg::cmd_t                cmd;

  assign cmd_ch.ready = !res_ch.valid || res_ch.ready;
  assign take         = cmd_ch.valid && cmd_ch.ready;
  assign cmd          = bsscb_pkg::cmd_t'(cmd_ch.command);

  // mask bits beyond the bank are dropped, lanes beyond the mask see zero
  for (genvar i = 0; i < bsscb_pkg::TAG_BITS; i++) begin : g_lane
    if (i < bsscb_pkg::MASK_W) begin : g_sel
      assign sel[i] = cmd_ch.bit_mask[i];
    end else begin : g_nosel
      assign sel[i] = 1'b0;
    end

    bsscb_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .en    (take),
      .cmd   (cmd),
      .sel   (sel[i]),
      .plane (cmd_ch.weight_plane),
      .flags (flags[i])
    );
  end

  bsscb_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .flags  (flags),
    .sel    (sel),
    .res_ch (res_ch)
  );

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    take |=> res_ch.valid)
    else $error("result missing after command transfer");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (take && (cmd == bsscb_pkg::CMD_CLEAR)) |=>
      (res_ch.nonzero_mask == '0) && !res_ch.any_multi && !res_ch.mask_hit)
    else $error("bank not empty after clear");

  a_multi_implies_hit: assert property (@(posedge clk) disable iff (rst)
    (res_ch.valid && res_ch.mask_multi_hit) |-> (res_ch.mask_hit && res_ch.any_multi))
    else $error("masked multi-count without hit or global multi");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (res_ch.valid && !res_ch.ready) |-> !take)
    else $error("command taken while output register is blocked");

endmodule

// ----- tb/sv/bit_sliced_saturating_counter_bank_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bit_sliced_saturating_counter_bank_core_tb
// Self-checking bench for the counter bank. A short table of directed
// commands exercises reset, saturation at both ends, empty masks and clear.
// Random bursts of clear/add/decrement/query commands follow. Results are
// compared field by field with typed rows' status or an in-bench bank model.
// The result side stalls on its own random pattern, with one long hold-off.
// ----------------------------------------------------------------------------
module bit_sliced_saturating_counter_bank_core_tb;
  import bsscb_pkg::*;

  localparam int RANDOM_ITEMS = 1950;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_LIMIT  = 5000;

  typedef struct packed {
    logic [MASK_W-1:0] nonzero_mask;
    logic              mask_hit;
    logic              mask_multi_hit;
    logic              any_multi;
  } bank_status_t;

  typedef struct {
    cmd_t               cmd;
    logic [MASK_W-1:0]  mask;
    logic [PLANE_W-1:0] plane;
    bit                 typed;
    bank_status_t       status;
  } directed_row_t;

  logic clk;
  logic rst;

  bsscb_cmd_if cmd_ch();
  bsscb_res_if res_ch();

  bit_sliced_saturating_counter_bank_core dut (
    .clk    (clk),
    .rst    (rst),
    .cmd_ch (cmd_ch),
    .res_ch (res_ch)
  );

  // Model of the bank: plane i holds bit i of every counter.
  logic [TAG_BITS-1:0] tally_plane [PLANES];
  bank_status_t        expected_status_q [$];

  bit           row_typed;
  bank_status_t row_status;
  bank_status_t predicted;
  bank_status_t want;
  bit           hold_req;
  int           errors;
  int           results_checked;
  int           n_clear, n_add, n_dec, n_query;
  int           saturating_adds, floored_decs;

  directed_row_t directed_rows [25] = '{
    '{CMD_QUERY, 32'hFFFF_FFFF, 3'd0, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b0}},
    '{CMD_ADD,   32'h0000_0001, 3'd0, 1'b1, '{32'h0000_0001, 1'b1, 1'b0, 1'b0}},
    '{CMD_ADD,   32'h0000_0001, 3'd0, 1'b1, '{32'h0000_0001, 1'b1, 1'b1, 1'b1}},
    '{CMD_QUERY, 32'h0000_0002, 3'd0, 1'b1, '{32'h0000_0001, 1'b0, 1'b0, 1'b1}},
    '{CMD_DEC,   32'h0000_0001, 3'd0, 1'b1, '{32'h0000_0001, 1'b1, 1'b0, 1'b0}},
    '{CMD_DEC,   32'h0000_0001, 3'd0, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b0}},
    // decrement of a zero counter stays at zero
    '{CMD_DEC,   32'h0000_0001, 3'd0, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b0}},
    '{CMD_ADD,   32'hFFFF_FFFF, 3'd7, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1}},
    // carry out of the top plane pins every counter at all ones
    '{CMD_ADD,   32'hFFFF_FFFF, 3'd7, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1}},
    '{CMD_ADD,   32'h8000_0000, 3'd0, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1}},
    '{CMD_DEC,   32'h0000_0000, 3'd0, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1}},
    // clear ignores the mask for the update but still reports through it
    '{CMD_CLEAR, 32'hFFFF_FFFF, 3'd5, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b0}},
    '{CMD_ADD,   32'h0000_0000, 3'd3, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b0}},
    '{CMD_ADD,   32'hA5A5_A5A5, 3'd3, 1'b0, '0},
    '{CMD_ADD,   32'h5A5A_5A5A, 3'd1, 1'b0, '0},
    '{CMD_DEC,   32'hFFFF_FFFF, 3'd0, 1'b0, '0},
    '{CMD_ADD,   32'h0000_FFFF, 3'd6, 1'b0, '0},
    '{CMD_ADD,   32'h0000_FFFF, 3'd6, 1'b0, '0},
    '{CMD_ADD,   32'h0000_FFFF, 3'd6, 1'b0, '0},
    '{CMD_ADD,   32'h0000_FFFF, 3'd6, 1'b0, '0},
    '{CMD_DEC,   32'h0000_FFFF, 3'd0, 1'b0, '0},
    '{CMD_QUERY, 32'hFFFF_0000, 3'd0, 1'b0, '0},
    '{CMD_ADD,   32'h0001_0000, 3'd4, 1'b0, '0},
    '{CMD_DEC,   32'h0001_0000, 3'd0, 1'b0, '0},
    '{CMD_CLEAR, 32'h0000_0000, 3'd0, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b0}}
  };

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one command to the model bank and return the status after it.
  function automatic bank_status_t step_counter_bank(cmd_t cmd, logic [MASK_W-1:0] mask,
                                                     logic [PLANE_W-1:0] plane);
    logic [63:0]         wide;
    logic [TAG_BITS-1:0] sel, ripple, nxt, nonzero, multi;
    bank_status_t        st;
    wide = 64'(mask);
    sel  = wide[TAG_BITS-1:0];
    case (cmd)
      CMD_CLEAR: begin
        n_clear++;
        for (int i = 0; i < PLANES; i++) tally_plane[i] = '0;
      end
      CMD_ADD: begin
        n_add++;
        ripple = sel;
        for (int i = int'(plane); i < PLANES; i++) begin
          nxt            = ripple & tally_plane[i];
          tally_plane[i] = tally_plane[i] ^ ripple;
          ripple         = nxt;
        end
        // carry out of the top plane: saturate those lanes
        if (ripple != '0) begin
          saturating_adds++;
          for (int i = 0; i < PLANES; i++) tally_plane[i] = tally_plane[i] | ripple;
        end
      end
      CMD_DEC: begin
        n_dec++;
        ripple = sel;
        for (int i = 0; i < PLANES; i++) begin
          nxt            = ripple & ~tally_plane[i];
          tally_plane[i] = tally_plane[i] ^ ripple;
          ripple         = nxt;
        end
        // borrow out of the top plane: the lane was zero, hold it there
        if (ripple != '0) begin
          floored_decs++;
          for (int i = 0; i < PLANES; i++) tally_plane[i] = tally_plane[i] & ~ripple;
        end
      end
      default: n_query++;
    endcase
    nonzero = '0;
    multi   = '0;
    for (int i = 0; i < PLANES; i++) begin
      nonzero = nonzero | tally_plane[i];
      if (i >= 1) multi = multi | tally_plane[i];
    end
    wide              = 64'(nonzero);
    st.nonzero_mask   = wide[MASK_W-1:0];
    st.mask_hit       = (sel & nonzero) != '0;
    st.mask_multi_hit = (sel & multi) != '0;
    st.any_multi      = multi != '0;
    return st;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act);
    if (exp_val !== act) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, act);
    end
  endfunction

  // Predict on every command transfer, then check any result transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        predicted = step_counter_bank(cmd_t'(cmd_ch.command), cmd_ch.bit_mask,
                                      cmd_ch.weight_plane);
        expected_status_q.push_back(row_typed ? row_status : predicted);
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_status_q.size() == 0) begin
          errors++;
          $display("%0t: result with no command pending: expected none, actual %h %b%b%b",
                   $time, res_ch.nonzero_mask, res_ch.mask_hit, res_ch.mask_multi_hit,
                   res_ch.any_multi);
        end else begin
          want = expected_status_q.pop_front();
          results_checked++;
          check_field("nonzero_mask", want.nonzero_mask, res_ch.nonzero_mask);
          check_field("mask_hit", 32'(want.mask_hit), 32'(res_ch.mask_hit));
          check_field("mask_multi_hit", 32'(want.mask_multi_hit), 32'(res_ch.mask_multi_hit));
          check_field("any_multi", 32'(want.any_multi), 32'(res_ch.any_multi));
        end
      end
    end
  end

  // Result side: random stretches of stalls, plus one long hold-off on request.
  initial begin
    bit hold_done;
    int mode, len;
    hold_done    = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        for (int k = 0; k < HOLD_CYCLES; k++) begin
          @(negedge clk);
          res_ch.ready <= 1'b0;
        end
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(4, 40);
        for (int k = 0; k < len; k++) begin
          @(negedge clk);
          case (mode)
            0:       res_ch.ready <= 1'b1;
            1:       res_ch.ready <= 1'($urandom_range(0, 1));
            2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
            default: res_ch.ready <= (k % 3 != 0);
          endcase
        end
      end
    end
  end

  task automatic send_command(cmd_t cmd, logic [MASK_W-1:0] mask, logic [PLANE_W-1:0] plane,
                              bit typed, bank_status_t status);
    @(negedge clk);
    cmd_ch.valid        <= 1'b1;
    cmd_ch.command      <= cmd;
    cmd_ch.bit_mask     <= mask;
    cmd_ch.weight_plane <= plane;
    row_typed           <= typed;
    row_status          <= status;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  // Drop valid for an idle stretch given by n; the payload carries noise meanwhile.
  task automatic idle_sender(int n);
    if (n > 0) begin
      @(negedge clk);
      cmd_ch.valid        <= 1'b0;
      cmd_ch.command      <= cmd_t'($urandom_range(0, 3));
      cmd_ch.bit_mask     <= $urandom;
      cmd_ch.weight_plane <= PLANE_W'($urandom_range(0, 7));
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_random();
    int           r;
    cmd_t         cmd;
    logic [31:0]  mask;
    logic [2:0]   plane;
    r = $urandom_range(0, 99);
    if (r < 4)       cmd = CMD_CLEAR;
    else if (r < 44) cmd = CMD_ADD;
    else if (r < 80) cmd = CMD_DEC;
    else             cmd = CMD_QUERY;
    case ($urandom_range(0, 9))
      0:       mask = '1;
      1:       mask = '0;
      2, 3:    mask = 32'h1 << $urandom_range(0, 31);
      4:       mask = 32'hFF << $urandom_range(0, 24);
      default: mask = $urandom;
    endcase
    r = $urandom_range(0, 99);
    if (r < 60)      plane = 3'd0;
    else if (r < 85) plane = 3'($urandom_range(1, 3));
    else             plane = 3'($urandom_range(4, 7));
    send_command(cmd, mask, plane, 1'b0, '0);
  endtask

  task automatic wait_drained();
    while (expected_status_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int  sent, burst;
    bit  paused;
    clk                 = 1'b0;
    rst                 = 1'b1;
    cmd_ch.valid        = 1'b0;
    cmd_ch.command      = CMD_QUERY;
    cmd_ch.bit_mask     = '0;
    cmd_ch.weight_plane = '0;
    row_typed           = 1'b0;
    row_status          = '0;
    hold_req            = 1'b0;
    paused              = 1'b0;
    for (int i = 0; i < PLANES; i++) tally_plane[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].cmd, directed_rows[i].mask, directed_rows[i].plane,
                   directed_rows[i].typed, directed_rows[i].status);
      idle_sender($urandom_range(0, 2));
    end
    idle_sender(1);
    wait_drained();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = (($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 24));
      for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        send_random();
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 8));
      // back the bank up: result side holds off while commands keep coming
      if (!hold_req && sent >= 700) begin
        hold_req = 1'b1;
        for (int b = 0; b < 60; b++) send_random();
        sent += 60;
      end
      if (!paused && sent >= 1300) begin
        idle_sender(1);
        wait_drained();
        paused = 1'b1;
      end
    end
    idle_sender(1);

    for (int k = 0; k < DRAIN_LIMIT && expected_status_q.size() != 0; k++) @(posedge clk);
    if (expected_status_q.size() != 0) begin
      errors += expected_status_q.size();
      $display("%0t: %0d results never arrived: expected 0 pending, actual %0d",
               $time, expected_status_q.size(), expected_status_q.size());
    end
    repeat (4) @(posedge clk);

    $display("covered %0d clear, %0d add, %0d decrement, %0d query commands; %0d results checked",
             n_clear, n_add, n_dec, n_query, results_checked);
    $display("saturating adds: %0d, decrements held at zero: %0d, errors: %0d",
             saturating_adds, floored_decs, errors);
    if (errors == 0) begin
      $display("bit_sliced_saturating_counter_bank_core regression: pass");
    end else begin
      $display("bit_sliced_saturating_counter_bank_core regression: fail");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("bit_sliced_saturating_counter_bank_core regression: fail");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/bsscb_pkg.sv
hw/rtl/bsscb_if.sv
hw/rtl/bsscb_lane.sv
hw/rtl/bsscb_merge.sv
hw/rtl/bit_sliced_saturating_counter_bank_core.sv
tb/sv/bit_sliced_saturating_counter_bank_core_tb.sv
